// File: rtl/uthx_pkg.sv
// ----------------------------------------------------------------------------
// UART hex serializer package
// Shared payload types, command codes and character constants for the
// 8N1 transmitter with its hex formatter.
// ----------------------------------------------------------------------------
package uthx_pkg;

  // Command codes carried by an input item.
  localparam logic [2:0] CMD_TICK       = 3'd0;
  localparam logic [2:0] CMD_RAW        = 3'd1;
  localparam logic [2:0] CMD_HEX_NIBBLE = 3'd2;
  localparam logic [2:0] CMD_HEX_BYTE   = 3'd3;
  localparam logic [2:0] CMD_HEX_WORD   = 3'd4;
  localparam logic [2:0] CMD_HEX_LWORD  = 3'd5;

  // Frame layout: start bit, eight data bits, stop bit.
  localparam logic [3:0] FRAME_BITS = 4'd10;
  localparam logic [9:0] FRAME_IDLE = 10'h3ff;

  // Reset value of the bit period register.
  localparam logic [15:0] BIT_CYCLES_RESET = 16'd434;

  // ASCII characters used by the hex formatter.
  localparam logic [7:0] CHAR_ZERO    = 8'h30;
  localparam logic [7:0] CHAR_LOWER_A = 8'h61;
  localparam logic [3:0] DIGIT_TEN    = 4'd10;

  // One input transaction.
  typedef struct packed {
    logic [2:0]  command;
    logic [31:0] value;
  } item_t;

  // One result transaction.
  typedef struct packed {
    logic tx_line;
    logic busy_res;
    logic rejected;
  } result_t;

  // A classified command as it travels from the front end to the engine.
  typedef struct packed {
    logic        is_send;
    logic        hex;
    logic [3:0]  digits;
    logic [31:0] value;
  } op_t;

  // Lowercase ASCII hex digit for a nibble.
  function automatic logic [7:0] hex_digit(input logic [3:0] d);
    logic [7:0] ch;
    if (d >= DIGIT_TEN) begin
      ch = {4'b0000, d} - {4'b0000, DIGIT_TEN} + CHAR_LOWER_A;
    end else begin
      ch = {4'b0000, d} + CHAR_ZERO;
    end
    return ch;
  endfunction

endpackage

// File: rtl/uthx_fifo.sv
// ----------------------------------------------------------------------------
// UART hex serializer queue
// Small first-in first-out buffer with a push/full and pop/empty interface.
// ----------------------------------------------------------------------------
module uthx_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             empty_o
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR  = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(DEPTH);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             wr_en;
  logic             rd_en;

  // Status flags and the head entry.
  assign full_o  = (count_q == FULL_CNT);
  assign empty_o = (count_q == '0);
  assign rdata_o = mem_q[rd_ptr_q];
  assign wr_en   = push_i & ~full_o;
  assign rd_en   = pop_i & ~empty_o;

  // Pointer and occupancy updates.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (wr_en) begin
      wr_ptr_d = (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
    end
    if (rd_en) begin
      rd_ptr_d = (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
    end
    if (wr_en && !rd_en) begin
      count_d = count_q + 1'b1;
    end else if (rd_en && !wr_en) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Storage needs no reset.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

// File: rtl/uthx_front.sv
// ----------------------------------------------------------------------------
// UART hex serializer front end
// Accepts input transactions and decodes each command into a send request
// with its digit count and a data word, left-aligned for the hex commands.
// ----------------------------------------------------------------------------
module uthx_front (
  input  logic            push,
  output logic            full,
  input  uthx_pkg::item_t item_i,
  input  logic            q_full_i,
  output logic            q_push_o,
  output uthx_pkg::op_t   op_o
);
  import uthx_pkg::*;

  // The input side is full whenever the command queue is.
  assign full     = q_full_i;
  assign q_push_o = push & ~q_full_i;

  // Decode the command. Unused codes act as a plain tick.
  always_comb begin
    op_o.is_send = 1'b1;
    op_o.hex     = 1'b1;
    op_o.digits  = 4'd0;
    op_o.value   = '0;
    case (item_i.command)
      CMD_RAW: begin
        op_o.hex    = 1'b0;
        op_o.digits = 4'd1;
        op_o.value  = {24'h000000, item_i.value[7:0]};
      end
      CMD_HEX_NIBBLE: begin
        op_o.digits = 4'd1;
        op_o.value  = {item_i.value[3:0], 28'h0000000};
      end
      CMD_HEX_BYTE: begin
        op_o.digits = 4'd2;
        op_o.value  = {item_i.value[7:0], 24'h000000};
      end
      CMD_HEX_WORD: begin
        op_o.digits = 4'd4;
        op_o.value  = {item_i.value[15:0], 16'h0000};
      end
      CMD_HEX_LWORD: begin
        op_o.digits = 4'd8;
        op_o.value  = item_i.value;
      end
      default: begin
        op_o.is_send = 1'b0;
        op_o.hex     = 1'b0;
      end
    endcase
  end

endmodule

// File: rtl/uthx_back.sv
// ----------------------------------------------------------------------------
// UART hex serializer engine
// Runs the bit timer, frame shifter and character sequencer, one queued tick
// per cycle while the result queue has room, and holds the bit period register.
// ----------------------------------------------------------------------------
module uthx_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [15:0]       cfg_data_i,
  input  logic              q_empty_i,
  input  uthx_pkg::op_t     op_i,
  output logic              q_pop_o,
  input  logic              r_full_i,
  output logic              r_push_o,
  output uthx_pkg::result_t res_o
);
  import uthx_pkg::*;

  logic [15:0] bit_cycles_q;
  logic        sending_q, sending_d;
  logic [31:0] value_hold_q, value_hold_d;
  logic [3:0]  chars_left_q, chars_left_d;
  logic        hex_mode_q, hex_mode_d;
  logic [9:0]  frame_q, frame_d;
  logic [3:0]  bit_index_q, bit_index_d;
  logic [15:0] tick_q, tick_d;
  logic [15:0] period;
  logic [7:0]  ch_first, ch_next;
  logic        step;
  logic        line;
  logic        busy;
  logic        rej;

  // The bit period register accepts a write in any cycle.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bit_cycles_q <= BIT_CYCLES_RESET;
    end else if (cfg_valid_i) begin
      bit_cycles_q <= cfg_data_i;
    end
  end

  // A period of zero behaves as one tick.
  assign period = (bit_cycles_q == '0) ? 16'd1 : bit_cycles_q;

  // One queued tick is executed whenever one is waiting and the result queue has room.
  assign step     = ~q_empty_i & ~r_full_i;
  assign q_pop_o  = step;
  assign r_push_o = step;

  // Next-state logic for one tick.
  always_comb begin
    sending_d    = sending_q;
    value_hold_d = value_hold_q;
    chars_left_d = chars_left_q;
    hex_mode_d   = hex_mode_q;
    frame_d      = frame_q;
    bit_index_d  = bit_index_q;
    tick_d       = tick_q;
    ch_first     = '0;
    ch_next      = '0;
    line         = 1'b1;
    busy         = 1'b0;
    rej          = 1'b0;
    if (step) begin
      // Start a new transfer, or flag the command when one is running.
      if (op_i.is_send) begin
        if (sending_q) begin
          rej = 1'b1;
        end else begin
          hex_mode_d   = op_i.hex;
          chars_left_d = op_i.digits;
          value_hold_d = op_i.value;
          sending_d    = 1'b1;
          ch_first     = op_i.hex ? hex_digit(op_i.value[31:28]) : op_i.value[7:0];
          if (op_i.hex) begin
            value_hold_d = {op_i.value[27:0], 4'h0};
          end
          frame_d     = {1'b1, ch_first, 1'b0};
          bit_index_d = '0;
          tick_d      = '0;
        end
      end
      // Drive the current bit and advance the bit timer.
      if (sending_d) begin
        busy   = 1'b1;
        line   = frame_d[0];
        tick_d = tick_d + 16'd1;
        if (tick_d >= period) begin
          tick_d      = '0;
          frame_d     = {1'b1, frame_d[9:1]};
          bit_index_d = bit_index_d + 4'd1;
          if (bit_index_d >= FRAME_BITS) begin
            chars_left_d = chars_left_d - 4'd1;
            if (chars_left_d == '0) begin
              sending_d   = 1'b0;
              frame_d     = FRAME_IDLE;
              bit_index_d = '0;
            end else begin
              ch_next = hex_mode_d ? hex_digit(value_hold_d[31:28]) : value_hold_d[7:0];
              if (hex_mode_d) begin
                value_hold_d = {value_hold_d[27:0], 4'h0};
              end
              frame_d     = {1'b1, ch_next, 1'b0};
              bit_index_d = '0;
              tick_d      = '0;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sending_q    <= 1'b0;
      value_hold_q <= '0;
      chars_left_q <= '0;
      hex_mode_q   <= 1'b0;
      frame_q      <= FRAME_IDLE;
      bit_index_q  <= '0;
      tick_q       <= '0;
    end else begin
      sending_q    <= sending_d;
      value_hold_q <= value_hold_d;
      chars_left_q <= chars_left_d;
      hex_mode_q   <= hex_mode_d;
      frame_q      <= frame_d;
      bit_index_q  <= bit_index_d;
      tick_q       <= tick_d;
    end
  end

  // Result transaction for this tick.
  assign res_o.tx_line  = line;
  assign res_o.busy_res = busy;
  assign res_o.rejected = rej;

endmodule

// File: rtl/uart_tx_hex_serializer_top.sv
// ----------------------------------------------------------------------------
// UART hex serializer top level
// 8N1 serial transmitter with a hex formatter. Each input transaction is one
// tick of baud timing and yields one result transaction.
//
//   Channel   Handshake            Payload
//   input     push / full          item_i   (command, value)
//   result    pop / empty          result_o (tx_line, busy_res, rejected)
//   config    cfg_valid_i/_ready_o cfg_data_i (bit_cycles)
//
// One input transaction is taken per cycle while full is low; the engine
// executes one queued tick per cycle while the result queue has room.
// Reset sets the bit period to 434 ticks and the line to idle high.
// When pop stays low, the result queue fills, then the command queue, and
// full rises; nothing is lost and the engine simply pauses.
// ----------------------------------------------------------------------------
module uart_tx_hex_serializer_top #(
  parameter int CMD_DEPTH = 2,
  parameter int RES_DEPTH = 2
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push,
  output logic              full,
  input  uthx_pkg::item_t   item_i,
  output logic              empty,
  input  logic              pop,
  output uthx_pkg::result_t result_o,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [15:0]       cfg_data_i
);
  import uthx_pkg::*;

  op_t     op_in, op_out;
  result_t res_in;
  logic    q_push, q_full, q_pop, q_empty;
  logic    r_push, r_full;

  // Front end: accept and decode commands.
  uthx_front u_front (
    .push     (push),
    .full     (full),
    .item_i   (item_i),
    .q_full_i (q_full),
    .q_push_o (q_push),
    .op_o     (op_in)
  );

  // Command queue between the front end and the engine.
  uthx_fifo #(
    .WIDTH ($bits(op_t)),
    .DEPTH (CMD_DEPTH)
  ) u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .wdata_i (op_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .rdata_o (op_out),
    .empty_o (q_empty)
  );

  // Transmit engine.
  uthx_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .q_empty_i   (q_empty),
    .op_i        (op_out),
    .q_pop_o     (q_pop),
    .r_full_i    (r_full),
    .r_push_o    (r_push),
    .res_o       (res_in)
  );

  // Result queue toward the consumer.
  uthx_fifo #(
    .WIDTH ($bits(result_t)),
    .DEPTH (RES_DEPTH)
  ) u_res_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (r_push),
    .wdata_i (res_in),
    .full_o  (r_full),
    .pop_i   (pop),
    .rdata_o (result_o),
    .empty_o (empty)
  );

`ifndef SYNTHESIS
  // Every tick taken from the command queue produces exactly one result.
  a_step_balance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop == r_push)
    else $error("command pop and result push out of step");

  // A rejected command can only occur during a frame.
  a_reject_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && result_o.rejected) |-> result_o.busy_res)
    else $error("rejection reported outside a frame");

  // The input side only becomes full after a transaction was pushed.
  a_full_rise: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(full) |-> $past(push))
    else $error("full rose without a push");
`endif

endmodule

// File: dv/uthx_line_monitor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UART hex serializer line monitor
// Watches the input, result and configuration channels of the serializer,
// predicts the line level, busy flag and reject flag of every tick, and
// compares each result transaction with the oldest prediction. The failure
// count and the number of predictions still waiting go to the testbench top.
// ----------------------------------------------------------------------------
module uthx_line_monitor (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push,
  input  logic              full,
  input  uthx_pkg::item_t   item_i,
  input  logic              empty,
  input  logic              pop,
  input  uthx_pkg::result_t result_i,
  input  logic              cfg_valid_i,
  input  logic              cfg_ready_i,
  input  logic [15:0]       cfg_data_i,
  output int unsigned       fail_count_o,
  output int unsigned       pending_o,
  output int unsigned       ticks_o,
  output int unsigned       chars_o,
  output int unsigned       rejects_o
);

  import uthx_pkg::*;

  localparam int unsigned MAX_REPORTS = 50;

  // Predicted transmitter state.
  logic [15:0] bit_period;
  logic        sending;
  logic [31:0] char_hold;
  logic [3:0]  chars_left;
  logic        hex_mode;
  logic [9:0]  frame_shift;
  logic [3:0]  bit_index;
  logic [15:0] tick_count;

  // Predicted results of accepted ticks, oldest first.
  result_t     tick_result_q[$];

  int unsigned fails;
  int unsigned pending;
  int unsigned ticks;
  int unsigned chars;
  int unsigned rejects;

  assign fail_count_o = fails;
  assign pending_o    = pending;
  assign ticks_o      = ticks;
  assign chars_o      = chars;
  assign rejects_o    = rejects;

  // Lowercase ASCII character for one hex digit.
  function automatic logic [7:0] nibble_char(input logic [3:0] nib);
    logic [7:0] wide;
    logic [7:0] ch;
    wide = {4'b0000, nib};
    if (nib < DIGIT_TEN) begin
      ch = CHAR_ZERO + wide;
    end else begin
      ch = CHAR_LOWER_A + wide - {4'b0000, DIGIT_TEN};
    end
    return ch;
  endfunction

  // Load the next character into the frame: start bit low, data, stop bit high.
  task automatic load_next_char();
    logic [7:0] ch;
    if (hex_mode) begin
      ch = nibble_char(char_hold[31:28]);
      char_hold = char_hold << 4;
    end else begin
      ch = char_hold[7:0];
    end
    frame_shift = {1'b1, ch, 1'b0};
    bit_index   = '0;
    tick_count  = '0;
  endtask

  // Advance the predicted transmitter by one tick.
  task automatic predict_tick(input item_t it, output result_t res);
    logic [15:0] period;
    logic [3:0]  digits;
    logic        is_send;
    period  = (bit_period == '0) ? 16'd1 : bit_period;
    res     = '0;
    res.tx_line = 1'b1;
    is_send = (it.command >= CMD_RAW) && (it.command <= CMD_HEX_LWORD);

    // A send command starts a new transmission only when the line is free.
    if (is_send) begin
      if (sending) begin
        res.rejected = 1'b1;
        rejects++;
      end else begin
        if (it.command == CMD_RAW) begin
          hex_mode   = 1'b0;
          chars_left = 4'd1;
          char_hold  = {24'h000000, it.value[7:0]};
        end else begin
          // Digits are left-aligned so the most significant one goes first.
          digits     = 4'd1 << (it.command - CMD_HEX_NIBBLE);
          hex_mode   = 1'b1;
          chars_left = digits;
          char_hold  = it.value << (6'd32 - {digits, 2'b00});
        end
        sending = 1'b1;
        load_next_char();
      end
    end

    // Bit timing and character sequencing.
    if (sending) begin
      res.busy_res = 1'b1;
      res.tx_line  = frame_shift[0];
      tick_count   = tick_count + 16'd1;
      if (tick_count >= period) begin
        tick_count  = '0;
        frame_shift = {1'b1, frame_shift[9:1]};
        bit_index   = bit_index + 4'd1;
        if (bit_index >= FRAME_BITS) begin
          chars++;
          chars_left = chars_left - 4'd1;
          if (chars_left == '0) begin
            sending     = 1'b0;
            frame_shift = FRAME_IDLE;
            bit_index   = '0;
          end else begin
            load_next_char();
          end
        end
      end
    end
  endtask

  // Compare one field of a result transaction.
  task automatic check_field(input string field, input logic want, input logic got);
    if (got !== want) begin
      if (fails < MAX_REPORTS) begin
        $display("time %0t: %s mismatch, expected %0b, actual %0b", $time, field, want, got);
      end
      fails++;
    end
  endtask

  // Channel watcher: compare results first, then predict the new tick.
  always @(posedge clk_i or negedge rst_ni) begin : watch
    result_t want;
    if (!rst_ni) begin
      bit_period  = BIT_CYCLES_RESET;
      sending     = 1'b0;
      char_hold   = '0;
      chars_left  = '0;
      hex_mode    = 1'b0;
      frame_shift = FRAME_IDLE;
      bit_index   = '0;
      tick_count  = '0;
      tick_result_q.delete();
      fails   = 0;
      ticks   = 0;
      chars   = 0;
      rejects = 0;
    end else begin
      if (pop && !empty) begin
        if (tick_result_q.size() == 0) begin
          if (fails < MAX_REPORTS) begin
            $display("time %0t: result transaction with no tick waiting, actual %b",
                     $time, result_i);
          end
          fails++;
        end else begin
          want = tick_result_q.pop_front();
          check_field("tx_line", want.tx_line, result_i.tx_line);
          check_field("busy_res", want.busy_res, result_i.busy_res);
          check_field("rejected", want.rejected, result_i.rejected);
        end
      end
      if (push && !full) begin
        predict_tick(item_i, want);
        tick_result_q.push_back(want);
        ticks++;
      end
      if (cfg_valid_i && cfg_ready_i) begin
        bit_period = cfg_data_i;
      end
    end
    pending = tick_result_q.size();
  end

endmodule

// File: dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UART hex serializer testbench
// Drives tick transactions with raw and hex send commands into the
// serializer over several bit periods, from zero up to the widest, with
// random gaps on both channels, and lets the line monitor check every tick.
// ----------------------------------------------------------------------------
module tb;

  import uthx_pkg::*;

  // Command codes that the block treats as plain ticks.
  localparam logic [2:0]  CMD_SPARE_6  = 3'd6;
  localparam logic [2:0]  CMD_SPARE_7  = 3'd7;
  localparam int unsigned IDLE_PERCENT = 37;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned MAX_CYCLES   = 200000;
  localparam int unsigned NUM_PHASES   = 6;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        push        = 1'b0;
  logic        full;
  item_t       item_i      = '0;
  logic        empty;
  logic        pop         = 1'b0;
  result_t     result_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [15:0] cfg_data_i  = '0;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned ticks;
  int unsigned chars;
  int unsigned rejects;
  int unsigned cycles = 0;
  bit          steady = 1'b0;

  int unsigned phase_period [NUM_PHASES];
  int unsigned phase_len    [NUM_PHASES];

  uart_tx_hex_serializer_top dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .item_i     (item_i),
    .empty      (empty),
    .pop        (pop),
    .result_o   (result_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_data_i (cfg_data_i)
  );

  uthx_line_monitor u_line_mon (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .item_i      (item_i),
    .empty       (empty),
    .pop         (pop),
    .result_i    (result_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_i (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .fail_count_o(fail_count),
    .pending_o   (pending),
    .ticks_o     (ticks),
    .chars_o     (chars),
    .rejects_o   (rejects)
  );

  // 10 ns clock.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // The result side stalls at random except during the steady stretch.
  always @(posedge clk_i) begin
    pop <= steady || ($urandom_range(0, 99) >= IDLE_PERCENT);
  end

  // Watchdog on the whole run.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= MAX_CYCLES) begin
      $display("Watchdog expired after %0d cycles with %0d ticks waiting", cycles, pending);
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Offer one tick transaction after a random gap and hold it until taken.
  task automatic send_item(input logic [2:0] cmd, input logic [31:0] value);
    item_t nxt;
    bit    taken;
    while (!steady && ($urandom_range(0, 99) < IDLE_PERCENT)) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    nxt.command = cmd;
    nxt.value   = value;
    push   <= 1'b1;
    item_i <= nxt;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk_i);
      taken = !full;
      @(posedge clk_i);
    end
  endtask

  // Wait until every tick has come out, then write the bit period.
  task automatic write_bit_cycles(input logic [15:0] period);
    bit taken;
    push <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= period;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk_i);
      taken = cfg_ready_o;
      @(posedge clk_i);
    end
    cfg_valid_i <= 1'b0;
  endtask

  initial begin
    int unsigned pick;
    int unsigned hex_pick;
    logic [2:0]  cmd;
    logic [31:0] value;

    phase_period = '{1, 2, 65535, 3, 0, 1};
    phase_len    = '{320, 220, 40, 150, 170, 150};
    phase_period[4] = $urandom_range(1, 6);

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Start a byte at the reset bit period, then switch to a zero period
    // mid-frame. The rest of that frame is ten ticks long, and every send
    // command in it is dropped, the one on the final stop-bit tick too.
    send_item(CMD_RAW, 32'h0000_003c);
    send_item(CMD_TICK, '1);
    write_bit_cycles(16'd0);
    send_item(CMD_RAW, '1);
    send_item(CMD_HEX_NIBBLE, '0);
    send_item(CMD_HEX_BYTE, 32'h8000_0001);
    send_item(CMD_HEX_WORD, '1);
    send_item(CMD_HEX_LWORD, 32'h0123_4567);
    send_item(CMD_SPARE_6, '1);
    send_item(CMD_SPARE_7, '0);
    send_item(CMD_TICK, 32'h5a5a_5a5a);
    send_item(CMD_TICK, '0);
    send_item(CMD_RAW, 32'h0000_00a5);

    // The first idle tick takes a new command at once.
    send_item(CMD_HEX_NIBBLE, 32'hffff_fffa);
    repeat (9) send_item(CMD_TICK, $urandom);
    send_item(CMD_HEX_BYTE, '0);

    // Random phases: mostly plain ticks with sends mixed in, so that frames
    // run to completion and some sends land while the line is busy.
    for (int p = 0; p < NUM_PHASES; p++) begin
      write_bit_cycles(phase_period[p][15:0]);
      for (int n = 0; n < phase_len[p]; n++) begin
        steady <= (p == 0) && (n >= 80) && (n < 240);
        pick = $urandom_range(0, 99);
        if (pick < 72) begin
          cmd = CMD_TICK;
        end else if (pick < 76) begin
          cmd = pick[0] ? CMD_SPARE_7 : CMD_SPARE_6;
        end else if (pick < 84) begin
          cmd = CMD_RAW;
        end else begin
          hex_pick = $urandom_range(CMD_HEX_NIBBLE, CMD_HEX_LWORD);
          cmd = hex_pick[2:0];
        end
        case ($urandom_range(0, 9))
          0:       value = '0;
          1:       value = '1;
          default: value = $urandom;
        endcase
        send_item(cmd, value);
      end
    end

    // Drain the result side.
    push   <= 1'b0;
    steady <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Ran %0d ticks at bit periods 434, 0, 1, 2, 3, %0d and 65535.",
             ticks, phase_period[4]);
    $display("Framed %0d characters and saw %0d sends rejected while busy.", chars, rejects);
    if (fail_count == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
